// File: src/stp_pkg.sv
package stp_pkg;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int HANDLE_W  = 3;
    localparam int BASE_W    = 31;
    localparam int TICK_W    = 24;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 3;
    localparam int ELAPSED_W = 32;
    localparam int CLK_W     = 10;
    localparam int MS_W      = 31;

    // Datapath widths: ms*1000 fits 41 bits, the signed total 43 bits
    localparam int PROD_W = 41;
    localparam int TOT_W  = 43;

    // Shared divider geometry
    localparam int DIV_DW = 42;
    localparam int DIV_VW = 31;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_ITER_TICK = DIV_CW'(TICK_W);
    localparam logic [DIV_CW-1:0] DIV_ITER_FULL = DIV_CW'(DIV_DW);

    // Defaults and constants
    localparam int NUM_SLOTS_DEF = 8;
    localparam logic [CLK_W-1:0] CLK_MHZ_RST = CLK_W'(48);
    localparam logic [PROD_W-1:0] MS_SCALE = PROD_W'(1000);
    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_OPEN   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CLOSE  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_GET    = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_GETCLR = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(5);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_ZERO_BASE = STATUS_W'(2);

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] count;
    } div_req_t;

endpackage

// File: src/soft_timer_pool.sv
// soft_timer_pool: a pool of NUM_SLOTS timers measured against a down-counting
// tick counter sample.
// Input channel (in_valid/in_ready) takes one command item: ms tick, open,
// close, get, get-and-clear or clear. Output channel (out_valid/out_ready)
// gives exactly one result item per command: status, slot_out, elapsed.
// cfg_we/cfg_data write clock_mhz (ticks per microsecond); write only when idle.
// One item at a time; in_ready is low while an item is worked on.
// Work from accept to out_valid, with the output register free:
//   close, bad handle, unknown, open with zero base: finished at accept; clear: via S_FIN
//   open: free-slot scan, one slot per cycle
//   ms tick: read-modify-write per used slot
//   get: runs the bit-serial divider twice
//        (24 steps for ticks/clock_mhz, 42 steps for total/base); the second
//        run is skipped when the total is not positive.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls with a result still held, the next item
// finishes and is held as a finished result, with in_ready low, until the
// register frees up.
// Reset clears all slot-in-use bits, the pending result and sets clock_mhz
// to 48. Slot storage itself is not cleared.
module soft_timer_pool #(
    parameter int NUM_SLOTS = stp_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stp_pkg::CLK_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [stp_pkg::CMD_W-1:0]       command,
    input  logic [stp_pkg::HANDLE_W-1:0]    handle,
    input  logic [stp_pkg::BASE_W-1:0]      base_time_us,
    input  logic [stp_pkg::TICK_W-1:0]      tick_now,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [stp_pkg::STATUS_W-1:0]    status,
    output logic [stp_pkg::SLOT_W-1:0]      slot_out,
    output logic [stp_pkg::ELAPSED_W-1:0]   elapsed
);
    import stp_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_TICK_RD = 10'b0000000010,
        S_TICK_WR = 10'b0000000100,
        S_OPEN    = 10'b0000001000,
        S_RD      = 10'b0000010000,
        S_DIFF    = 10'b0000100000,
        S_DIV1    = 10'b0001000000,
        S_CHK     = 10'b0010000000,
        S_DIV2    = 10'b0100000000,
        S_FIN     = 10'b1000000000
    } state_t;

    // S_DONE folded as a flag: result ready to move to the output register
    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [CLK_W-1:0]     clk_mhz_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [SW-1:0]        hidx_reg, hidx_next;
    logic [BASE_W-1:0]    base_in_reg, base_in_next;
    logic [TICK_W-1:0]    now_reg, now_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [ELAPSED_W-1:0] res_elapsed_reg, res_elapsed_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [ELAPSED_W-1:0] out_elapsed_reg, out_elapsed_next;

    // Slot storage, single address per cycle
    logic [BASE_W-1:0] base_mem [NUM_SLOTS];
    logic [MS_W-1:0]   ms_mem   [NUM_SLOTS];
    logic [TICK_W-1:0] last_mem [NUM_SLOTS];
    logic [BASE_W-1:0] base_rd_reg;
    logic [MS_W-1:0]   ms_rd_reg;
    logic [TICK_W-1:0] last_rd_reg;
    logic [SW-1:0]     mem_addr;
    logic              rd_en, we_base, we_ms, we_last;
    logic [BASE_W-1:0] wd_base;
    logic [MS_W-1:0]   wd_ms;
    logic [TICK_W-1:0] wd_last;

    // Divider hookup
    div_req_t          div_req;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic              div_done;
    logic [DIV_DW-1:0] div_quo;

    // Datapath helpers
    logic              accept;
    logic              hvalid;
    logic [CLK_W-1:0]  clk_eff;
    logic [TICK_W:0]   diff;
    logic [TICK_W:0]   diff_neg;
    logic [TICK_W-1:0] mag;
    logic [TOT_W-1:0]  q1_ext;
    logic [TOT_W-1:0]  q1_signed;
    logic              total_pos;

    stp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ready = (state_reg == S_IDLE) && !done_reg;
    assign accept   = in_valid && in_ready;
    assign hvalid   = {{(32-HANDLE_W){1'b0}}, handle} < 32'(NUM_SLOTS);

    assign clk_eff   = (clk_mhz_reg == '0) ? CLK_W'(1) : clk_mhz_reg;
    assign diff      = {1'b0, last_rd_reg} - {1'b0, now_reg};
    assign diff_neg  = '0 - diff;
    assign mag       = diff[TICK_W] ? diff_neg[TICK_W-1:0] : diff[TICK_W-1:0];
    assign q1_ext    = {{(TOT_W-TICK_W){1'b0}}, div_quo[TICK_W-1:0]};
    assign q1_signed = neg_reg ? ('0 - q1_ext) : q1_ext;
    assign total_pos = !total_reg[TOT_W-1] && (total_reg != '0);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        done_next        = done_reg;
        used_next        = used_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        hidx_next        = hidx_reg;
        base_in_next     = base_in_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        total_next       = total_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_elapsed_next = res_elapsed_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_elapsed_next = out_elapsed_reg;

        mem_addr = hidx_reg;
        rd_en    = 1'b0;
        we_base  = 1'b0;
        we_ms    = 1'b0;
        we_last  = 1'b0;
        wd_base  = base_in_reg;
        wd_ms    = '0;
        wd_last  = now_reg;

        div_req.start = 1'b0;
        div_req.count = DIV_ITER_FULL;
        div_dividend  = total_reg[DIV_DW-1:0];
        div_divisor   = base_rd_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = command;
                    hidx_next        = SW'(handle);
                    base_in_next     = base_time_us;
                    now_next         = tick_now;
                    idx_next         = '0;
                    res_status_next  = ST_OK;
                    res_slot_next    = '0;
                    res_elapsed_next = '0;
                    done_next        = 1'b1;
                    unique case (command)
                        CMD_TICK:
                        begin
                            done_next  = 1'b0;
                            state_next = S_TICK_RD;
                        end
                        CMD_OPEN:
                        begin
                            if (base_time_us == '0)
                            begin
                                res_status_next = ST_ZERO_BASE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_OPEN;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            if (hvalid)
                            begin
                                used_next[SW'(handle)] = 1'b0;
                            end
                        end
                        CMD_GET, CMD_GETCLR:
                        begin
                            if (hvalid)
                            begin
                                done_next  = 1'b0;
                                state_next = S_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (hvalid)
                            begin
                                done_next  = 1'b0;
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // ms tick: read count of each used slot, then write it back + 1, saturating at MS_MAX
            S_TICK_RD:
            begin
                mem_addr = idx_reg;
                if (used_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = S_TICK_WR;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            S_TICK_WR:
            begin
                mem_addr = idx_reg;
                if (ms_rd_reg != MS_MAX)
                begin
                    we_ms = 1'b1;
                    wd_ms = ms_rd_reg + MS_W'(1);
                end
                if (idx_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = S_TICK_RD;
                end
            end

            // open: scan for the lowest free slot
            S_OPEN:
            begin
                mem_addr = idx_reg;
                if (!used_reg[idx_reg])
                begin
                    used_next[idx_reg] = 1'b1;
                    we_base       = 1'b1;
                    we_ms         = 1'b1;
                    we_last       = 1'b1;
                    res_slot_next = SLOT_W'(idx_reg);
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_status_next = ST_NO_SLOT;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DIFF;
            end

            // ticks since last sample / clock_mhz, and ms*1000
            S_DIFF:
            begin
                div_req.start = 1'b1;
                div_req.count = DIV_ITER_TICK;
                div_dividend  = {mag, {(DIV_DW-TICK_W){1'b0}}};
                div_divisor   = {{(DIV_VW-CLK_W){1'b0}}, clk_eff};
                neg_next      = diff[TICK_W];
                prod_next     = PROD_W'(ms_rd_reg) * MS_SCALE;
                state_next    = S_DIV1;
            end

            S_DIV1:
            begin
                if (div_done)
                begin
                    total_next = {{(TOT_W-PROD_W){1'b0}}, prod_reg} + q1_signed;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if ((base_rd_reg == '0) || !total_pos)
                begin
                    res_elapsed_next = '0;
                    state_next       = S_FIN;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV2;
                end
            end

            S_DIV2:
            begin
                if (div_done)
                begin
                    res_elapsed_next = (|div_quo[DIV_DW-1:ELAPSED_W]) ?
                                       '1 : div_quo[ELAPSED_W-1:0];
                    state_next       = S_FIN;
                end
            end

            // finish; restart measurement for get-and-clear and clear
            S_FIN:
            begin
                if ((cmd_reg == CMD_GETCLR) || (cmd_reg == CMD_CLEAR))
                begin
                    we_ms   = 1'b1;
                    we_last = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the finished result to the output register
        if (done_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next   = 1'b1;
            out_status_next  = res_status_reg;
            out_slot_next    = res_slot_reg;
            out_elapsed_next = res_elapsed_reg;
            done_next        = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            clk_mhz_reg   <= CLK_MHZ_RST;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                clk_mhz_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        hidx_reg        <= hidx_next;
        base_in_reg     <= base_in_next;
        now_reg         <= now_next;
        idx_reg         <= idx_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        total_reg       <= total_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_elapsed_reg <= res_elapsed_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_elapsed_reg <= out_elapsed_next;
    end

    // Slot memories
    always_ff @(posedge clk)
    begin
        if (we_base)
        begin
            base_mem[mem_addr] <= wd_base;
        end
        if (we_ms)
        begin
            ms_mem[mem_addr] <= wd_ms;
        end
        if (we_last)
        begin
            last_mem[mem_addr] <= wd_last;
        end
        if (rd_en)
        begin
            base_rd_reg <= base_mem[mem_addr];
            ms_rd_reg   <= ms_mem[mem_addr];
            last_rd_reg <= last_mem[mem_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign slot_out  = out_slot_reg;
    assign elapsed   = out_elapsed_reg;

endmodule

// File: src/stp_div.sv
module stp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stp_pkg::div_req_t           req,
    input  logic [stp_pkg::DIV_DW-1:0]  dividend,
    input  logic [stp_pkg::DIV_VW-1:0]  divisor,
    output logic                        done,
    output logic [stp_pkg::DIV_DW-1:0]  quotient
);
    import stp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_VW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [DIV_VW-1:0] dvs_reg, dvs_next;

    logic [DIV_VW:0]   shifted;
    logic [DIV_VW+1:0] sub;
    logic              ge;

    // One restoring step per cycle; dividend enters left-aligned
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_DW-1]};
        sub       = {1'b0, shifted} - {2'b00, dvs_reg};
        ge        = ~sub[DIV_VW+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? sub[DIV_VW-1:0] : shifted[DIV_VW-1:0];
            quo_next = {quo_reg[DIV_DW-2:0], ge};
            cnt_next = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/stp_checker.sv
module stp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [stp_pkg::STATUS_W-1:0]    status,
    input logic [stp_pkg::SLOT_W-1:0]      slot_out,
    input logic [stp_pkg::ELAPSED_W-1:0]   elapsed
);
    import stp_pkg::*;

    // an accepted item always makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an item was accepted");

    // a failed open carries no slot and no elapsed time
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (slot_out == '0) && (elapsed == '0))
        else $error("failed open carries slot or elapsed value");

    // open result and get result never mix
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (elapsed != '0) |-> (status == ST_OK) && (slot_out == '0))
        else $error("elapsed result mixed with open fields");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(elapsed) && $stable(status))
        else $error("stalled result changed or dropped");

endmodule

bind soft_timer_pool stp_checker u_stp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot_out  (slot_out),
    .elapsed   (elapsed)
);
